// ===== hdl/sflc_pkg.sv =====
package sflc_pkg;

  localparam int unsigned POS_W     = 17;
  localparam int unsigned LEN_W     = 17;
  localparam int unsigned CNT_W     = POS_W + 1;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [LEN_W-1:0] HDR_LEN      = LEN_W'(20);
  localparam logic [POS_W-1:0] ATTR_HDR_IDX = POS_W'(20);
  localparam logic [CNT_W-1:0] ATTR_HDR_LEN = CNT_W'(4);
  localparam int unsigned      TYPE_SHIFT   = 6;
  localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_PAD_ALIGN       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WALK_ATTRIBUTES = 1'b1;

  typedef enum logic [1:0] {
    STATUS_VALID      = 2'd0,
    STATUS_INVALID    = 2'd1,
    STATUS_INCOMPLETE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_TYPE_HI = 2'd0,
    PH_TYPE_LO = 2'd1,
    PH_LEN_HI  = 2'd2,
    PH_LEN_LO  = 2'd3
  } attr_phase_t;

  typedef struct packed {
    logic pad_align;
    logic walk_attributes;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic last_byte;
  } byte_ctl_t;

  typedef struct packed {
    status_t          status;
    logic [LEN_W-1:0] message_length;
  } verdict_t;

endpackage

// ===== hdl/stun_frame_length_check_core.sv =====
// Checks the framing of a STUN message carried in one datagram, taking one datagram
// byte per word on the input channel and returning one verdict word for the byte
// marked last (status 0 valid, 1 invalid, 2 incomplete, with the message length when
// valid). The core sustains one byte per cycle: every byte is parsed in the cycle it
// is accepted by a single pass of counter and compare logic, and a verdict is held
// in a one-word output register, so the input stalls only while that register holds
// a verdict the receiver has not yet taken. The verdict appears in the cycle after
// its last byte is accepted. The padding register (index 0) and the walk_attributes
// register (index 1) reset to 1 and should be written only between datagrams with
// no verdict pending.
module stun_frame_length_check_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_data_byte,
  input  logic                                in_last_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic [sflc_pkg::LEN_W-1:0]          out_message_length,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sflc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic                                cfg_data
);

  // Configuration registers; writes are always taken.
  sflc_pkg::cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        sflc_pkg::CFG_PAD_ALIGN:       cfg_nxt.pad_align       = cfg_data;
        sflc_pkg::CFG_WALK_ATTRIBUTES: cfg_nxt.walk_attributes = cfg_data;
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{pad_align: 1'b1, walk_attributes: 1'b1};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // A byte is taken whenever the output register is empty or being drained.
  sflc_pkg::byte_ctl_t ctl;
  sflc_pkg::verdict_t  verdict;
  logic                out_free;

  assign in_ready      = out_free;
  assign ctl.accept    = in_valid && in_ready;
  assign ctl.last_byte = in_last_byte;

  sflc_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .ctl       (ctl),
    .data_byte (in_data_byte),
    .verdict   (verdict)
  );

  // Only the last byte of a datagram produces a verdict word.
  sflc_out u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (ctl.accept && ctl.last_byte),
    .verdict            (verdict),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_message_length (out_message_length),
    .free               (out_free)
  );

`ifndef SYNTHESIS
  // A valid verdict always covers at least the 20-byte header.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == sflc_pkg::STATUS_VALID |-> out_message_length >= 17'd20)
    else $error("valid verdict with length below header size");

  // Non-valid verdicts report a zero length.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != sflc_pkg::STATUS_VALID |-> out_message_length == '0)
    else $error("non-valid verdict with nonzero length");

  // A byte that does not close the datagram leaves no verdict behind.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last_byte |=> !out_valid)
    else $error("verdict produced for a non-final byte");

  // The closing byte always yields a verdict in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_byte |=> out_valid)
    else $error("no verdict after final byte");
`endif

endmodule

// ===== hdl/sflc_parse.sv =====
module sflc_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  sflc_pkg::cfg_t     cfg,
  input  sflc_pkg::byte_ctl_t ctl,
  input  logic [7:0]         data_byte,
  output sflc_pkg::verdict_t verdict
);

  logic [sflc_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]                 len_hi_r, len_hi_nxt;
  logic [sflc_pkg::LEN_W-1:0] total_r, total_nxt;
  logic                       first_bad_r, first_bad_nxt;
  sflc_pkg::attr_phase_t      phase_r, phase_nxt;
  logic [sflc_pkg::LEN_W-1:0] skip_r, skip_nxt;
  logic                       walk_fail_r, walk_fail_nxt;

  logic [sflc_pkg::CNT_W-1:0] cnt;
  logic [sflc_pkg::LEN_W-1:0] alen;
  logic [sflc_pkg::LEN_W-1:0] remaining;

  always_comb begin
    pos_nxt       = pos_r;
    len_hi_nxt    = len_hi_r;
    total_nxt     = total_r;
    first_bad_nxt = first_bad_r;
    phase_nxt     = phase_r;
    skip_nxt      = skip_r;
    walk_fail_nxt = walk_fail_r;
    verdict       = '{status: sflc_pkg::STATUS_VALID, message_length: '0};

    cnt       = {1'b0, pos_r} + sflc_pkg::CNT_W'(1);
    remaining = total_r - cnt[sflc_pkg::LEN_W-1:0];
    alen      = {1'b0, len_hi_r, data_byte};
    if (cfg.pad_align) begin
      alen = (alen + sflc_pkg::LEN_W'(3)) & ~sflc_pkg::LEN_W'(3);
    end

    if (ctl.accept) begin
      if (pos_r == '0) begin
        first_bad_nxt = (data_byte >> sflc_pkg::TYPE_SHIFT) != 8'd0;
      end else if (pos_r == sflc_pkg::POS_W'(2)) begin
        len_hi_nxt = data_byte;
      end else if (pos_r == sflc_pkg::POS_W'(3)) begin
        total_nxt = {1'b0, len_hi_r, data_byte} + sflc_pkg::HDR_LEN;
      end else if (pos_r >= sflc_pkg::ATTR_HDR_IDX && pos_r < total_r) begin
        // Attribute walk: skip value bytes, then collect the next 4-byte header.
        if (!walk_fail_r) begin
          if (skip_r != '0) begin
            skip_nxt = skip_r - sflc_pkg::LEN_W'(1);
          end else begin
            case (phase_r)
              sflc_pkg::PH_TYPE_HI: phase_nxt = sflc_pkg::PH_TYPE_LO;
              sflc_pkg::PH_TYPE_LO: phase_nxt = sflc_pkg::PH_LEN_HI;
              sflc_pkg::PH_LEN_HI: begin
                len_hi_nxt = data_byte;
                phase_nxt  = sflc_pkg::PH_LEN_LO;
              end
              default: begin
                if (alen > remaining) begin
                  walk_fail_nxt = 1'b1;
                end else begin
                  skip_nxt = alen;
                end
                phase_nxt = sflc_pkg::PH_TYPE_HI;
              end
            endcase
          end
          // A header cut off by the end of the message is an overrun.
          if (cnt == {1'b0, total_r} && phase_nxt != sflc_pkg::PH_TYPE_HI) begin
            walk_fail_nxt = 1'b1;
          end
        end
      end

      if (ctl.last_byte) begin
        if (first_bad_nxt) begin
          verdict.status = sflc_pkg::STATUS_INVALID;
        end else if (cnt < sflc_pkg::ATTR_HDR_LEN) begin
          verdict.status = sflc_pkg::STATUS_INCOMPLETE;
        end else if (cfg.pad_align && total_nxt[1:0] != 2'b00) begin
          verdict.status = sflc_pkg::STATUS_INVALID;
        end else if (cnt < {1'b0, total_nxt}) begin
          verdict.status = sflc_pkg::STATUS_INCOMPLETE;
        end else if (cfg.walk_attributes && walk_fail_nxt) begin
          verdict.status = sflc_pkg::STATUS_INVALID;
        end else begin
          verdict.status         = sflc_pkg::STATUS_VALID;
          verdict.message_length = total_nxt;
        end
        pos_nxt       = '0;
        len_hi_nxt    = '0;
        total_nxt     = '0;
        first_bad_nxt = 1'b0;
        phase_nxt     = sflc_pkg::PH_TYPE_HI;
        skip_nxt      = '0;
        walk_fail_nxt = 1'b0;
      end else begin
        pos_nxt = (pos_r == sflc_pkg::POS_MAX) ? pos_r : cnt[sflc_pkg::POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      len_hi_r    <= '0;
      total_r     <= '0;
      first_bad_r <= 1'b0;
      phase_r     <= sflc_pkg::PH_TYPE_HI;
      skip_r      <= '0;
      walk_fail_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      len_hi_r    <= len_hi_nxt;
      total_r     <= total_nxt;
      first_bad_r <= first_bad_nxt;
      phase_r     <= phase_nxt;
      skip_r      <= skip_nxt;
      walk_fail_r <= walk_fail_nxt;
    end
  end

endmodule

// ===== hdl/sflc_out.sv =====
module sflc_out (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  sflc_pkg::verdict_t         verdict,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [sflc_pkg::LEN_W-1:0] out_message_length,
  output logic                       free
);

  logic               valid_r, valid_nxt;
  sflc_pkg::verdict_t data_r;

  assign free      = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= verdict;
    end
  end

  assign out_valid          = valid_r;
  assign out_status         = data_r.status;
  assign out_message_length = data_r.message_length;

endmodule

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The watchdog ends the run after this many cycles in which no word moves on any
  // channel.
  localparam int unsigned WDOG_LIMIT = 5000;

  // Random traffic stops once both of these are reached, spread over four phases.
  localparam int unsigned RAND_BYTES   = 600;
  localparam int unsigned RAND_PACKETS = 16;
  localparam int unsigned NUM_PHASES   = 4;

  typedef bit [7:0] byte_q_t[$];

  logic                                 clk;
  logic                                 rst_n;
  logic                                 in_valid;
  logic                                 in_ready;
  logic [7:0]                           in_data_byte;
  logic                                 in_last_byte;
  logic                                 out_valid;
  logic                                 out_ready;
  logic [1:0]                           out_status;
  logic [sflc_pkg::LEN_W-1:0]           out_message_length;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [sflc_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic                                 cfg_data;

  stun_frame_length_check_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_message_length (out_message_length),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // 10 ns clock. All stimulus changes on the falling edge and every output is
  // sampled on the rising edge, so nothing depends on event order inside a step.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the parser: register values and per-datagram state.
  logic                       pad_on;
  logic                       walk_on;
  logic [sflc_pkg::POS_W-1:0] pos_cnt;
  logic [7:0]                 len_hi;
  logic [sflc_pkg::LEN_W-1:0] msg_len;
  logic                       hdr_bad;
  sflc_pkg::attr_phase_t      attr_ph;
  logic [sflc_pkg::LEN_W-1:0] skip_cnt;
  logic                       walk_bad;

  // Verdicts predicted for datagrams whose last byte has been accepted, oldest first.
  sflc_pkg::verdict_t verdict_q[$];

  // Datagram currently being assembled by the generators below.
  byte_q_t pkt;

  // Flow-control knobs, in percent of cycles.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  int unsigned errors;
  int unsigned bytes_sent;
  int unsigned packets_sent;
  int unsigned verdicts_seen;
  int unsigned status_hits[3];
  int unsigned idle_cycles;

  task automatic clear_datagram_state();
    pos_cnt  = '0;
    len_hi   = '0;
    msg_len  = '0;
    hdr_bad  = 1'b0;
    attr_ph  = sflc_pkg::PH_TYPE_HI;
    skip_cnt = '0;
    walk_bad = 1'b0;
  endtask

  // Attribute walk on one body byte. The header is type (2 bytes) then length
  // (2 bytes); the value that follows is skipped, rounded up to a multiple of four
  // when padding is on. Any overrun of the message latches walk_bad.
  task automatic walk_body_byte(input int unsigned idx, input logic [7:0] b);
    int unsigned alen;
    int unsigned remaining;
    if (!walk_bad) begin
      if (skip_cnt != 0) begin
        skip_cnt = skip_cnt - 1'b1;
      end else if (attr_ph == sflc_pkg::PH_TYPE_HI) begin
        attr_ph = sflc_pkg::PH_TYPE_LO;
      end else if (attr_ph == sflc_pkg::PH_TYPE_LO) begin
        attr_ph = sflc_pkg::PH_LEN_HI;
      end else if (attr_ph == sflc_pkg::PH_LEN_HI) begin
        len_hi  = b;
        attr_ph = sflc_pkg::PH_LEN_LO;
      end else begin
        alen      = 32'({len_hi, b});
        remaining = msg_len - (idx + 1);
        if (pad_on)
          alen = (alen + 3) & ~32'd3;
        if (alen > remaining)
          walk_bad = 1'b1;
        else
          skip_cnt = sflc_pkg::LEN_W'(alen);
        attr_ph = sflc_pkg::PH_TYPE_HI;
      end
      // The message ending in the middle of an attribute header is an overrun too.
      if (idx + 1 == msg_len && attr_ph != sflc_pkg::PH_TYPE_HI)
        walk_bad = 1'b1;
    end
  endtask

  // Advances the shadow parser by one accepted byte and, on the last byte of a
  // datagram, queues the verdict the core must return.
  task automatic predict_byte(input logic [7:0] b, input logic last);
    int unsigned        idx;
    int unsigned        count;
    sflc_pkg::verdict_t v;
    idx   = 32'(pos_cnt);
    count = idx + 1;
    if (idx == 0)
      hdr_bad = (b[7:6] != 2'b00);
    else if (idx == 2)
      len_hi = b;
    else if (idx == 3)
      msg_len = {1'b0, len_hi, b} + sflc_pkg::HDR_LEN;
    else if (idx >= sflc_pkg::ATTR_HDR_IDX && idx < msg_len)
      walk_body_byte(idx, b);

    if (!last) begin
      pos_cnt = (pos_cnt < sflc_pkg::POS_MAX) ? pos_cnt + 1'b1 : sflc_pkg::POS_MAX;
    end else begin
      v.message_length = '0;
      if (hdr_bad)
        v.status = sflc_pkg::STATUS_INVALID;
      else if (count < sflc_pkg::ATTR_HDR_LEN)
        v.status = sflc_pkg::STATUS_INCOMPLETE;
      else if (pad_on && msg_len[1:0] != 2'b00)
        v.status = sflc_pkg::STATUS_INVALID;
      else if (count < msg_len)
        v.status = sflc_pkg::STATUS_INCOMPLETE;
      else if (walk_on && walk_bad)
        v.status = sflc_pkg::STATUS_INVALID;
      else begin
        v.status         = sflc_pkg::STATUS_VALID;
        v.message_length = msg_len;
      end
      verdict_q.push_back(v);
      clear_datagram_state();
    end
  endtask

  // Sends one byte word. Idle cycles are inserted before it at the sender's
  // current rate; valid then stays up, with the payload held, until accepted.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_data_byte = b;
    in_last_byte = last;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    predict_byte(b, last);
    bytes_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++)
      send_byte(pkt[i], i == pkt.size() - 1);
    packets_sent++;
  endtask

  // Register writes happen only with the core idle: every queued verdict has come
  // back and the output register has emptied.
  task automatic write_register(input logic [sflc_pkg::CFG_IDX_W-1:0] idx,
                                input logic value);
    while (verdict_q.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    if (idx == sflc_pkg::CFG_PAD_ALIGN)
      pad_on = value;
    else if (idx == sflc_pkg::CFG_WALK_ATTRIBUTES)
      walk_on = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(input logic pad, input logic walk);
    write_register(sflc_pkg::CFG_PAD_ALIGN, pad);
    write_register(sflc_pkg::CFG_WALK_ATTRIBUTES, walk);
  endtask

  // Starts a datagram with a well-formed 20-byte header whose length word is
  // body_len. The cookie and transaction id bytes are random.
  task automatic start_header(input int unsigned body_len);
    pkt = {};
    pkt.push_back({2'b00, 6'($urandom_range(0, 63))});
    pkt.push_back(8'($urandom));
    pkt.push_back(body_len[15:8]);
    pkt.push_back(body_len[7:0]);
    repeat (16) pkt.push_back(8'($urandom));
  endtask

  task automatic add_attribute(input int unsigned alen, input int unsigned pad_len);
    pkt.push_back(8'($urandom));
    pkt.push_back(8'($urandom));
    pkt.push_back(alen[15:8]);
    pkt.push_back(alen[7:0]);
    repeat (alen + pad_len) pkt.push_back(8'($urandom));
  endtask

  // Well-formed message with random attributes; the length word is patched at
  // the end to cover exactly the body that was built.
  task automatic build_message(input int unsigned n_attr, input int unsigned max_alen,
                               input bit padded);
    int unsigned alen;
    int unsigned body;
    start_header(0);
    for (int i = 0; i < n_attr; i++) begin
      alen = $urandom_range(0, max_alen);
      add_attribute(alen, padded ? (4 - alen % 4) % 4 : 0);
    end
    body   = pkt.size() - 20;
    pkt[2] = body[15:8];
    pkt[3] = body[7:0];
  endtask

  // First byte with the type bits set, lengths below four bytes, and the length
  // word at both extremes, checked on the header alone.
  task automatic test_header_checks();
    pkt = '{8'hC0};                             send_packet();
    pkt = '{8'h40, 8'h01, 8'h00, 8'h00};        send_packet();
    pkt = '{8'h80};                             send_packet();
    pkt = '{8'h00};                             send_packet();
    pkt = '{8'h3F, 8'hFF};                      send_packet();
    pkt = '{8'h00, 8'h01, 8'h00};               send_packet();
    // Length word 1 gives a message of 21 bytes, which is misaligned.
    pkt = '{8'h00, 8'h01, 8'h00, 8'h01};        send_packet();
    // Largest length word: misaligned with padding on, incomplete with it off.
    pkt = '{8'h01, 8'h01, 8'hFF, 8'hFF};        send_packet();
    set_config(1'b0, 1'b1);
    pkt = '{8'h01, 8'h01, 8'hFF, 8'hFF};        send_packet();
    set_config(1'b1, 1'b1);
    // Header-only message, valid at exactly 20 bytes.
    start_header(0);
    send_packet();
  endtask

  // Attribute headers and values that fit, overrun the message, or end early.
  task automatic test_attribute_walk();
    // One empty attribute, then bytes past the message end that must be ignored.
    start_header(4);
    add_attribute(0, 0);
    repeat (5) pkt.push_back(8'($urandom));
    send_packet();
    // Value length 8 in a body of 4 overruns the message.
    start_header(4);
    add_attribute(8, 0);
    send_packet();
    // Message ends inside an attribute header: invalid with the walk on, valid off.
    set_config(1'b0, 1'b1);
    start_header(2);
    pkt.push_back(8'h00);
    pkt.push_back(8'h01);
    send_packet();
    set_config(1'b0, 1'b0);
    start_header(2);
    pkt.push_back(8'h00);
    pkt.push_back(8'h01);
    send_packet();
    // Walk off skips the overrun check even with padding on.
    set_config(1'b1, 1'b0);
    start_header(4);
    add_attribute(8, 0);
    send_packet();
    set_config(1'b1, 1'b1);
  endtask

  // A one-byte value padded to four: it fits whether or not the length is rounded up.
  task automatic test_padding_modes();
    start_header(8);
    add_attribute(1, 3);
    send_packet();
    set_config(1'b0, 1'b1);
    start_header(8);
    add_attribute(1, 3);
    send_packet();
    // Unpadded odd lengths are fine when padding is off.
    start_header(5);
    add_attribute(1, 0);
    send_packet();
    set_config(1'b1, 1'b1);
  endtask

  // Mostly well-formed messages with random content, some broken on purpose, and
  // some plain noise, across every register setting and flow-control mode.
  task automatic test_random_traffic();
    int unsigned phase_bytes;
    int unsigned phase_pkts;
    int unsigned start_bytes;
    int unsigned sel;
    int unsigned r;
    int unsigned n;
    sel = 0;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      start_bytes = bytes_sent;
      phase_pkts  = 0;
      phase_bytes = 0;
      while (phase_bytes < RAND_BYTES / NUM_PHASES ||
             phase_pkts < RAND_PACKETS / NUM_PHASES) begin
        // Step through all four register settings every few datagrams.
        if (phase_pkts % 6 == 0) begin
          set_config(~sel[0], ~sel[1]);
          sel++;
        end
        r = $urandom_range(0, 99);
        if (r < 12) begin
          pkt = {};
          n   = $urandom_range(1, 30);
          repeat (n) pkt.push_back(8'($urandom));
        end else begin
          build_message($urandom_range(0, 3), $urandom_range(0, 9),
                        (r < 80) ? bit'(pad_on) : bit'($urandom_range(0, 1)));
          if (r >= 65) begin
            case ($urandom_range(0, 5))
              0: begin
                n   = $urandom_range(1, pkt.size() - 1);
                pkt = pkt[0:n-1];
              end
              1: begin
                n = $urandom_range(1, 6);
                repeat (n) pkt.push_back(8'($urandom));
              end
              2: pkt[3] = pkt[3] + 8'($urandom_range(1, 7));
              3: pkt[3] = pkt[3] - 8'($urandom_range(1, 7));
              4: pkt[0][7:6] = 2'($urandom_range(1, 3));
              default: pkt[2] = 8'($urandom);
            endcase
          end
        end
        send_packet();
        phase_pkts++;
        phase_bytes = bytes_sent - start_bytes;
      end
    end
  endtask

  // The receiver stalls at its current rate, redrawn every cycle.
  always @(negedge clk) begin
    if (rst_n)
      out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Each verdict word is checked against the oldest prediction.
  always @(posedge clk) begin
    sflc_pkg::verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: verdict with none expected: status=%0d length=%0d",
                 $time, out_status, out_message_length);
      end else begin
        want = verdict_q.pop_front();
        verdicts_seen++;
        status_hits[want.status]++;
        if (out_status !== want.status) begin
          errors++;
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, out_status);
        end
        if (out_message_length !== want.message_length) begin
          errors++;
          $display("%0t: message_length mismatch: expected %0d, actual %0d",
                   $time, want.message_length, out_message_length);
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no word moving on any channel means the
  // core has hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WDOG_LIMIT) begin
          $display("%0t: watchdog expired with %0d verdicts outstanding",
                   $time, verdict_q.size());
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data_byte   = '0;
    in_last_byte   = 1'b0;
    out_ready      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    errors         = 0;
    bytes_sent     = 0;
    packets_sent   = 0;
    verdicts_seen  = 0;
    idle_cycles    = 0;
    status_hits    = '{0, 0, 0};
    // Both registers come out of reset set.
    pad_on  = 1'b1;
    walk_on = 1'b1;
    clear_datagram_state();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_header_checks();
    test_attribute_walk();
    test_padding_modes();
    test_random_traffic();

    // Drain, then leave time for a stray extra verdict to show up.
    while (verdict_q.size() != 0)
      @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Sent %0d datagrams (%0d bytes) over four register settings and four",
             packets_sent, bytes_sent);
    $display("flow-control modes; verdicts: %0d valid, %0d invalid, %0d incomplete.",
             status_hits[sflc_pkg::STATUS_VALID], status_hits[sflc_pkg::STATUS_INVALID],
             status_hits[sflc_pkg::STATUS_INCOMPLETE]);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sflc_pkg.sv
hdl/sflc_parse.sv
hdl/sflc_out.sv
hdl/stun_frame_length_check_core.sv
verif/tb.sv
